// ===== src/adsr_envelope_generator_defines.svh =====
// Assertion macros used by the envelope generator checker.
`ifndef ADSR_ENVELOPE_GENERATOR_DEFINES_SVH
`define ADSR_ENVELOPE_GENERATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adsr envelope check failed");

// The consequent must hold in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adsr envelope check failed");

`endif

// ===== src/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope generator.
package adsr_pkg;

  localparam int VOICES   = 8;
  localparam int VOICE_AW = (VOICES > 1) ? $clog2(VOICES) : 1;

  localparam int VOICE_W  = 3;
  localparam int LEVEL_W  = 24;
  localparam int RATE_W   = 25;
  localparam int ENTRY_W  = LEVEL_W + 1;
  localparam int PROD_W   = 2 * RATE_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [LEVEL_W-1:0] ONE_Q23    = 24'd8388608;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL  = 24'd10485760;
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 24'd4194304;
  localparam logic [RATE_W-1:0]  ONE_Q24    = 25'd16777216;
  localparam logic [RATE_W-1:0]  HALF_Q24   = 25'd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_RATE   = 3'd0,
    CFG_DECAY_RATE    = 3'd1,
    CFG_SUSTAIN_LEVEL = 3'd2,
    CFG_RELEASE_RATE  = 3'd3,
    CFG_CURVED        = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_WRITE
  } state_e;

endpackage

// ===== src/adsr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module adsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/adsr_envelope_generator.sv =====
// Bank of exponential ADSR envelopes, one voice advanced by one sample tick per item.
// Each item names a voice, an optional retrigger that enters attack first, and a gate.
// The envelope state of every voice (24-bit Q1.23 level and an attack flag) sits in a
// RAM with registered read data; each item is read, updated and written back before
// the next item is taken. All products run through one shared 25x25 multiplier: an
// attack tick makes one multiplier pass and a decay or release tick makes three,
// between the RAM read and the write back, and the FSM returns to idle before the next
// item is taken. A finished item waits in the output register, and the next item may
// be accepted while it waits. After reset every voice reads as level 0, not attacking,
// through per-voice valid bits; no clearing pass is needed. Registers are written
// through the configuration port, which is always ready.
module adsr_envelope_generator import adsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [VOICE_W-1:0]   voice_i,
  input  logic                 retrigger_i,
  input  logic                 gate_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VOICE_W-1:0]   voice_out_o,
  output logic [LEVEL_W-1:0]   level_o,
  output logic                 attacking_o
);

  logic [RATE_W-1:0]  attack_rate_q;
  logic [RATE_W-1:0]  decay_rate_q;
  logic [LEVEL_W-1:0] sustain_q;
  logic [RATE_W-1:0]  release_rate_q;
  logic               curved_q;

  state_e state_q, state_d;

  logic [VOICE_W-1:0]  voice_q;
  logic                trig_q;
  logic                gate_q;
  logic [LEVEL_W-1:0]  lvl_q, lvl_d;
  logic                att_q, att_d;
  logic [LEVEL_W-1:0]  mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [VOICES-1:0]   valid_q;

  logic                out_valid_q;
  logic [VOICE_W-1:0]  out_voice_q;
  logic [LEVEL_W-1:0]  out_level_q;
  logic                out_att_q;

  logic                in_acc;
  logic                in_range;
  logic [VOICE_AW-1:0] vaddr;
  logic [ENTRY_W-1:0]  rd_data;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                mul_en;
  logic [RATE_W-1:0]   mul_a;
  logic [RATE_W-1:0]   mul_b;
  logic                out_free;
  logic                out_load;
  logic                attack_mode;

  logic [LEVEL_W-1:0]  rd_lvl;
  logic                rd_att;
  logic [RATE_W-1:0]   shape_w;
  logic [RATE_W-1:0]   shape_rate;
  logic [PROD_W-24:0]  term;
  logic [RATE_W-1:0]   factor;
  logic [RATE_W+1:0]   att_sum;
  logic [LEVEL_W-1:0]  prod_p;
  logic [RATE_W-1:0]   decay_res;
  logic [LEVEL_W-1:0]  new_lvl;
  logic                new_att;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_rate_q  <= '0;
      decay_rate_q   <= '0;
      sustain_q      <= SUSTAIN_RST;
      release_rate_q <= '0;
      curved_q       <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ATTACK_RATE:   attack_rate_q  <= cfg_data_i;
        CFG_DECAY_RATE:    decay_rate_q   <= cfg_data_i;
        CFG_SUSTAIN_LEVEL: sustain_q      <= cfg_data_i[LEVEL_W-1:0];
        CFG_RELEASE_RATE:  release_rate_q <= cfg_data_i;
        CFG_CURVED:        curved_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(voice_q) < VOICES);
  assign vaddr      = VOICE_AW'(voice_q);

  adsr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (VOICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (vaddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (VOICE_AW'(voice_i)),
    .rdata_o (rd_data)
  );

  // A voice that was never written reads as level zero and, unless retriggered, not attacking.
  assign rd_lvl = valid_q[vaddr] ? rd_data[LEVEL_W-1:0] : '0;
  assign rd_att = (valid_q[vaddr] && rd_data[LEVEL_W]) || trig_q;

  assign attack_mode = gate_q && att_q;
  assign shape_rate  = gate_q ? decay_rate_q : release_rate_q;
  assign shape_w     = curved_q ? prod_q[RATE_W+22:23] : {1'b0, ONE_Q23};
  assign term        = prod_q[PROD_W-1:23];
  assign factor      = (term >= (PROD_W-23)'(HALF_Q24)) ? HALF_Q24
                       : RATE_W'((PROD_W-23)'(ONE_Q24) - term);

  assign att_sum   = (RATE_W+2)'(lvl_q) + (RATE_W+2)'(prod_q[PROD_W-1:24]);
  assign prod_p    = prod_q[LEVEL_W+23:24];
  assign decay_res = neg_q ? ({1'b0, sustain_q} - {1'b0, prod_p})
                           : ({1'b0, sustain_q} + {1'b0, prod_p});

  always_comb begin
    new_lvl = prod_p;
    new_att = att_q;
    if (attack_mode) begin
      if (att_sum >= (RATE_W+2)'(ONE_Q23)) begin
        new_lvl = ONE_Q23;
        new_att = 1'b0;
      end else begin
        new_lvl = att_sum[LEVEL_W-1:0];
      end
    end else if (gate_q) begin
      new_lvl = (decay_res > {1'b0, MAX_LEVEL}) ? MAX_LEVEL : decay_res[LEVEL_W-1:0];
    end
  end

  assign ram_wdata = {new_att, new_lvl};
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    lvl_d    = lvl_q;
    att_d    = att_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        lvl_d = rd_lvl;
        att_d = rd_att;
        neg_d = rd_lvl < sustain_q;
        if (!gate_q) begin
          mag_d = rd_lvl;
        end else if (rd_lvl < sustain_q) begin
          mag_d = sustain_q - rd_lvl;
        end else begin
          mag_d = rd_lvl - sustain_q;
        end
        state_d = in_range ? S_MUL1 : S_WRITE;
      end
      S_MUL1: begin
        mul_en = 1'b1;
        if (attack_mode) begin
          mul_a   = attack_rate_q;
          mul_b   = {1'b0, MAX_LEVEL - lvl_q};
          state_d = S_WRITE;
        end else begin
          mul_a   = {1'b0, mag_q};
          mul_b   = {1'b0, mag_q};
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        mul_en  = 1'b1;
        mul_a   = shape_rate;
        mul_b   = shape_w;
        state_d = S_MUL3;
      end
      S_MUL3: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, mag_q};
        mul_b   = factor;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          out_load = 1'b1;
          ram_we   = in_range;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        valid_q[vaddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      voice_q <= voice_i;
      trig_q  <= retrigger_i;
      gate_q  <= gate_i;
    end
    lvl_q <= lvl_d;
    att_q <= att_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    if (mul_en) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      out_voice_q <= voice_q;
      out_level_q <= in_range ? new_lvl : '0;
      out_att_q   <= in_range && new_att;
    end
  end

  assign out_valid_o = out_valid_q;
  assign voice_out_o = out_voice_q;
  assign level_o     = out_level_q;
  assign attacking_o = out_att_q;

endmodule

// ===== src/adsr_checker.sv =====
// Port-level checker for the ADSR envelope generator, bound to the top level.
`include "adsr_envelope_generator_defines.svh"

module adsr_checker import adsr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [VOICE_W-1:0] voice_out_o,
  input logic [LEVEL_W-1:0] level_o,
  input logic               attacking_o
);

  `ADSR_ASSERT_NOW(a_level_range, out_valid_o, level_o <= MAX_LEVEL)
  `ADSR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `ADSR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(level_o) && $stable(voice_out_o) && $stable(attacking_o))

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (.*);

// ===== bench/adsr_envelope_generator_test.sv =====
// Self-checking testbench for the ADSR envelope generator: directed and random ticks vs a predictor.
module adsr_envelope_generator_test;
  import adsr_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RAND_PHASES     = 6;
  localparam int TICKS_PER_PHASE = 150;
  localparam int N_DIR           = 22;
  localparam int N_DIR_SETS      = 4;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef struct packed {
    logic [RATE_W-1:0]  atk_rate;
    logic [RATE_W-1:0]  dec_rate;
    logic [LEVEL_W-1:0] sus_level;
    logic [RATE_W-1:0]  rel_rate;
    logic               curve_on;
  } env_settings_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [VOICE_W-1:0] voice;
    logic               retrig;
    logic               gate_on;
    logic               known;
    logic [LEVEL_W-1:0] level;
    logic               attacking;
  } tick_row_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic [LEVEL_W-1:0] level;
    logic               attacking;
  } env_result_t;

  localparam env_settings_t DIR_SETS [N_DIR_SETS] = '{
    '{'0, '0, SUSTAIN_RST, '0, 1'b0},
    '{RATE_MAX, '0, '1, RATE_MAX, 1'b0},
    '{ONE_Q24, ONE_Q24, '0, '0, 1'b1},
    '{RATE_W'(1), RATE_W'(1), ONE_Q23, ONE_Q24, 1'b1}
  };

  localparam tick_row_t DIR_TICKS [N_DIR] = '{
    '{2'd0, 3'd0, 1'b0, 1'b1, 1'b1, '0, 1'b0},
    '{2'd0, 3'd7, 1'b1, 1'b1, 1'b1, '0, 1'b1},
    '{2'd0, 3'd7, 1'b0, 1'b0, 1'b1, '0, 1'b1},
    '{2'd0, 3'd4, 1'b0, 1'b0, 1'b1, '0, 1'b0},
    '{2'd1, 3'd7, 1'b0, 1'b1, 1'b1, ONE_Q23, 1'b0},
    '{2'd1, 3'd7, 1'b0, 1'b1, 1'b1, ONE_Q23, 1'b0},
    '{2'd1, 3'd7, 1'b0, 1'b0, 1'b1, ONE_Q23 >> 1, 1'b0},
    '{2'd1, 3'd7, 1'b0, 1'b0, 1'b1, ONE_Q23 >> 2, 1'b0},
    '{2'd1, 3'd3, 1'b1, 1'b0, 1'b1, '0, 1'b1},
    '{2'd1, 3'd3, 1'b0, 1'b1, 1'b1, ONE_Q23, 1'b0},
    '{2'd1, 3'd3, 1'b1, 1'b1, 1'b1, ONE_Q23, 1'b0},
    '{2'd2, 3'd1, 1'b1, 1'b1, 1'b0, '0, 1'b0},
    '{2'd2, 3'd1, 1'b0, 1'b1, 1'b0, '0, 1'b0},
    '{2'd2, 3'd1, 1'b0, 1'b1, 1'b0, '0, 1'b0},
    '{2'd2, 3'd1, 1'b0, 1'b0, 1'b0, '0, 1'b0},
    '{2'd2, 3'd6, 1'b1, 1'b1, 1'b0, '0, 1'b0},
    '{2'd3, 3'd2, 1'b1, 1'b1, 1'b0, '0, 1'b0},
    '{2'd3, 3'd5, 1'b0, 1'b1, 1'b0, '0, 1'b0},
    '{2'd3, 3'd5, 1'b0, 1'b0, 1'b0, '0, 1'b0},
    '{2'd3, 3'd1, 1'b0, 1'b0, 1'b0, '0, 1'b0},
    '{2'd3, 3'd6, 1'b0, 1'b0, 1'b0, '0, 1'b0},
    '{2'd3, 3'd3, 1'b0, 1'b1, 1'b0, '0, 1'b0}
  };

  logic                 clk = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [RATE_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [VOICE_W-1:0]   voice_i = '0;
  logic                 retrigger_i = 1'b0;
  logic                 gate_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [VOICE_W-1:0]   voice_out_o;
  logic [LEVEL_W-1:0]   level_o;
  logic                 attacking_o;

  env_settings_t      cur_set;
  logic [LEVEL_W-1:0] voice_level [VOICES];
  logic               voice_attacking [VOICES];
  bit                 held_notes [2**VOICE_W];
  env_result_t        pending_results [$];

  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;

  adsr_envelope_generator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .voice_i     (voice_i),
    .retrigger_i (retrigger_i),
    .gate_i      (gate_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .voice_out_o (voice_out_o),
    .level_o     (level_o),
    .attacking_o (attacking_o)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [LEVEL_W-1:0] limit_level(longint x);
    if (x < 0) return '0;
    if (x > longint'(MAX_LEVEL)) return MAX_LEVEL;
    return x[LEVEL_W-1:0];
  endfunction

  function automatic longint shape_factor(logic [RATE_W-1:0] rate, longint dmag);
    longint w;
    longint term;
    longint f;
    w = cur_set.curve_on ? ((dmag * dmag) >>> 23) : longint'(ONE_Q23);
    term = (longint'(rate) * w) >>> 23;
    f = longint'(ONE_Q24) - term;
    if (f < longint'(HALF_Q24)) f = longint'(HALF_Q24);
    if (f > 2 * longint'(ONE_Q24)) f = 2 * longint'(ONE_Q24);
    return f;
  endfunction

  function automatic env_result_t advance_voice(logic [VOICE_W-1:0] v, logic retrig,
                                                logic gate_on);
    env_result_t res;
    longint lvl;
    longint sus;
    longint d;
    longint mag;
    longint p;
    res = '0;
    res.voice = v;
    if (v >= VOICES) return res;
    if (retrig) voice_attacking[v] = 1'b1;
    lvl = voice_level[v];
    sus = cur_set.sus_level;
    if (gate_on && voice_attacking[v]) begin
      lvl = limit_level(lvl + ((longint'(cur_set.atk_rate) * (longint'(MAX_LEVEL) - lvl)) >>> 24));
      if (lvl >= longint'(ONE_Q23)) begin
        lvl = ONE_Q23;
        voice_attacking[v] = 1'b0;
      end
    end else if (gate_on) begin
      d = lvl - sus;
      mag = (d < 0) ? -d : d;
      p = (mag * shape_factor(cur_set.dec_rate, mag)) >>> 24;
      lvl = limit_level((d < 0) ? sus - p : sus + p);
    end else begin
      lvl = limit_level((lvl * shape_factor(cur_set.rel_rate, lvl)) >>> 24);
    end
    voice_level[v] = lvl[LEVEL_W-1:0];
    res.level = lvl[LEVEL_W-1:0];
    res.attacking = voice_attacking[v];
    return res;
  endfunction

  function automatic int unsigned idle_cycles();
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RATE_MAX;
      2: return ONE_Q24;
      3: return RATE_W'($urandom_range(1, 255));
      4, 5, 6: return RATE_W'($urandom_range(1 << 18, 1 << 22));
      default: return RATE_W'($urandom);
    endcase
  endfunction

  function automatic env_settings_t random_settings();
    env_settings_t s;
    s.atk_rate = pick_rate();
    s.dec_rate = pick_rate();
    s.rel_rate = pick_rate();
    s.curve_on = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: s.sus_level = '0;
      1: s.sus_level = ONE_Q23;
      2: s.sus_level = MAX_LEVEL;
      3: s.sus_level = '1;
      4: s.sus_level = LEVEL_W'($urandom);
      default: s.sus_level = LEVEL_W'($urandom_range(0, MAX_LEVEL));
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    $display("MISMATCH cycle %0d: %s expected %0d, got %0d", cycle_count, what, want, got);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(env_settings_t s);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(CFG_ATTACK_RATE, s.atk_rate);
    write_reg(CFG_DECAY_RATE, s.dec_rate);
    write_reg(CFG_SUSTAIN_LEVEL, RATE_W'({$urandom, s.sus_level}));
    write_reg(CFG_RELEASE_RATE, s.rel_rate);
    write_reg(CFG_CURVED, RATE_W'({$urandom, s.curve_on}));
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_CURVED) + 1, 2**CFG_IDX_W - 1)),
                RATE_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
    cur_set = s;
    settings_used++;
  endtask

  task automatic send_tick(logic [VOICE_W-1:0] v, logic retrig, logic gate_on, logic known,
                           env_result_t typed);
    int unsigned gap;
    env_result_t res;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    voice_i <= v;
    retrigger_i <= retrig;
    gate_i <= gate_on;
    do @(posedge clk); while (in_stall_o);
    res = advance_voice(v, retrig, gate_on);
    pending_results.push_back(known ? typed : res);
    ticks_sent++;
  endtask

  always @(posedge clk) begin
    env_result_t want;
    int unsigned n;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, voice_out", 0, voice_out_o);
      end else begin
        want = pending_results.pop_front();
        if (voice_out_o !== want.voice) report_mismatch("voice_out", want.voice, voice_out_o);
        if (level_o !== want.level) report_mismatch("level", want.level, level_o);
        if (attacking_o !== want.attacking) begin
          report_mismatch("attacking", want.attacking, attacking_o);
        end
      end
      n = idle_cycles();
    end else if (stall_left > 1) begin
      n = stall_left - 1;
    end else begin
      n = ($urandom_range(0, 7) == 0) ? idle_cycles() : 0;
    end
    stall_left <= n;
    out_stall_i <= (n != 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    env_result_t typed;
    tick_row_t row;
    logic [VOICE_W-1:0] v;
    logic retrig;
    logic gate_on;
    int unsigned phase_now;
    cur_set = DIR_SETS[0];
    for (int i = 0; i < VOICES; i++) begin
      voice_level[i] = '0;
      voice_attacking[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    phase_now = 0;
    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_TICKS[i];
      if (row.phase != phase_now) begin
        phase_now = row.phase;
        apply_settings(DIR_SETS[phase_now]);
      end
      typed.voice = row.voice;
      typed.level = row.level;
      typed.attacking = row.attacking;
      send_tick(row.voice, row.retrig, row.gate_on, row.known, typed);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      calm = 1'b0;
      apply_settings(random_settings());
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        v = VOICE_W'($urandom_range(0, 2**VOICE_W - 1));
        if (!held_notes[v]) begin
          if ($urandom_range(0, 4) == 0) begin
            retrig = 1'b1;
            gate_on = 1'b1;
            held_notes[v] = 1'b1;
          end else begin
            retrig = ($urandom_range(0, 19) == 0);
            gate_on = 1'b0;
          end
        end else if ($urandom_range(0, 11) == 0) begin
          retrig = 1'b0;
          gate_on = 1'b0;
          held_notes[v] = 1'b0;
        end else begin
          retrig = ($urandom_range(0, 29) == 0);
          gate_on = 1'b1;
        end
        send_tick(v, retrig, gate_on, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Sent %0d ticks under %0d register settings, directed then random.",
             ticks_sent, settings_used);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
